// ===== src/rtt_estimator_with_backoff_assert.svh =====
// ---------------------------------------------------------------------------
// RTT estimator assertion macros
// Concurrent assertion wrappers; empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef RTT_ESTIMATOR_WITH_BACKOFF_ASSERT_SVH
`define RTT_ESTIMATOR_WITH_BACKOFF_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define RTTE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define RTTE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define RTTE_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define RTTE_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ===== src/rtte_pkg.sv =====
// ---------------------------------------------------------------------------
// RTT estimator package
// Shared widths, reset values, request codes and state/result types.
// ---------------------------------------------------------------------------
`default_nettype none

package rtte_pkg;

    localparam int RTT_W = 16;
    localparam int TMO_W = 32;

    localparam logic [RTT_W-1:0] EST_RESET = 16'd100;
    localparam logic [RTT_W-1:0] DEV_RESET = 16'd10;
    localparam logic [TMO_W-1:0] TIMEOUT_MAX = 32'hFFFF_FFFF;

    localparam logic REQ_SAMPLE  = 1'b0;
    localparam logic REQ_TIMEOUT = 1'b1;

    typedef struct packed {
        logic [RTT_W-1:0] est;
        logic [RTT_W-1:0] dev;
        logic [TMO_W-1:0] backoff;
        logic             active;
    } t_state;

    typedef struct packed {
        logic [TMO_W-1:0] timeout_ms;
        logic [RTT_W-1:0] smoothed_rtt;
        logic [RTT_W-1:0] rtt_deviation;
    } t_result;

endpackage

`default_nettype wire

// ===== src/rtte_calc.sv =====
// ---------------------------------------------------------------------------
// RTT estimator update logic
// Next estimator state and reported timeout for one sample or timeout item.
// ---------------------------------------------------------------------------
`default_nettype none

module rtte_calc (
    input  wire logic                    i_req_type,
    input  wire logic [rtte_pkg::RTT_W-1:0] i_rtt_sample,
    input  wire rtte_pkg::t_state        i_state,
    output rtte_pkg::t_state             o_state,
    output rtte_pkg::t_result            o_result
);

    // est + 4*dev, below 2^19
    function automatic logic [rtte_pkg::TMO_W-1:0] base_timeout(
        input logic [rtte_pkg::RTT_W-1:0] est,
        input logic [rtte_pkg::RTT_W-1:0] dev
    );
        base_timeout = {{(rtte_pkg::TMO_W-rtte_pkg::RTT_W){1'b0}}, est}
                     + {{(rtte_pkg::TMO_W-rtte_pkg::RTT_W-2){1'b0}}, dev, 2'b00};
    endfunction

    logic [rtte_pkg::RTT_W+2:0] w_est7;
    logic [rtte_pkg::RTT_W+1:0] w_dev3;
    logic [rtte_pkg::RTT_W-1:0] w_est_new;
    logic [rtte_pkg::RTT_W-1:0] w_dev_new;
    logic [rtte_pkg::RTT_W-1:0] w_diff;
    logic [rtte_pkg::TMO_W-1:0] w_base_new;
    logic [rtte_pkg::TMO_W-1:0] w_bo_src;
    logic [rtte_pkg::TMO_W-1:0] w_bo_dbl;

    always_comb begin
        w_est7    = {3'b000, i_state.est} * 19'd7;
        w_est_new = w_est7[rtte_pkg::RTT_W+2:3] + {3'b000, i_rtt_sample[rtte_pkg::RTT_W-1:3]};
        w_diff    = (i_rtt_sample >= w_est_new) ? (i_rtt_sample - w_est_new)
                                                : (w_est_new - i_rtt_sample);
        w_dev3    = {2'b00, i_state.dev} * 18'd3;
        w_dev_new = w_dev3[rtte_pkg::RTT_W+1:2] + {2'b00, w_diff[rtte_pkg::RTT_W-1:2]};
        w_base_new = base_timeout(w_est_new, w_dev_new);

        // first timeout doubles the base, later ones double the held value
        w_bo_src = i_state.active ? i_state.backoff
                                  : base_timeout(i_state.est, i_state.dev);
        w_bo_dbl = w_bo_src[rtte_pkg::TMO_W-1] ? rtte_pkg::TIMEOUT_MAX
                                               : {w_bo_src[rtte_pkg::TMO_W-2:0], 1'b0};

        if (i_req_type == rtte_pkg::REQ_SAMPLE) begin
            o_state.est     = w_est_new;
            o_state.dev     = w_dev_new;
            o_state.backoff = '0;
            o_state.active  = 1'b0;
            o_result.timeout_ms = w_base_new;
        end else begin
            o_state.est     = i_state.est;
            o_state.dev     = i_state.dev;
            o_state.backoff = w_bo_dbl;
            o_state.active  = 1'b1;
            o_result.timeout_ms = w_bo_dbl;
        end
        o_result.smoothed_rtt  = o_state.est;
        o_result.rtt_deviation = o_state.dev;
    end

endmodule

`default_nettype wire

// ===== src/rtt_estimator_with_backoff.sv =====
// ---------------------------------------------------------------------------
// RTT estimator with backoff
// Smoothed round-trip / deviation tracking with exponential timeout backoff.
// ---------------------------------------------------------------------------
// Each item is a round-trip sample or a timeout event and yields one result.
// The block takes one item per clock while no stalled result holds it off.
// An accepted item is captured in an input register; once the result slot is
// free or draining, the estimator state and the result register are updated
// together through a single pass of shift/add logic. A result held by a
// stalled receiver holds the input register and drops the input ready until
// it is taken. The state recurrence is one register around combinational
// logic, so back-to-back items see each other's updates. Reset loads an
// estimate of 100 ms, a deviation of 10 ms and clears the backoff.
`default_nettype none

`include "rtt_estimator_with_backoff_assert.svh"

module rtt_estimator_with_backoff (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic                        i_req_type,
    input  wire logic [rtte_pkg::RTT_W-1:0]  i_rtt_sample,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [rtte_pkg::TMO_W-1:0]       o_timeout_ms,
    output logic [rtte_pkg::RTT_W-1:0]       o_smoothed_rtt,
    output logic [rtte_pkg::RTT_W-1:0]       o_rtt_deviation
);

    logic                       r_in_valid;
    logic                       r_in_req;
    logic [rtte_pkg::RTT_W-1:0] r_in_sample;
    rtte_pkg::t_state           r_state;
    rtte_pkg::t_state           n_state;
    rtte_pkg::t_result          n_result;
    rtte_pkg::t_result          r_result;
    logic                       r_out_valid;
    logic                       w_adv;

    // result slot free or being drained this cycle
    assign w_adv   = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || w_adv;

    rtte_calc u_calc (
        .i_req_type   (r_in_req),
        .i_rtt_sample (r_in_sample),
        .i_state      (r_state),
        .o_state      (n_state),
        .o_result     (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_state.est     <= rtte_pkg::EST_RESET;
            r_state.dev     <= rtte_pkg::DEV_RESET;
            r_state.backoff <= '0;
            r_state.active  <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_valid <= i_valid;
            end
            if (w_adv) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_req    <= i_req_type;
            r_in_sample <= i_rtt_sample;
        end
        if (w_adv) begin
            r_result <= n_result;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_timeout_ms    = r_result.timeout_ms;
    assign o_smoothed_rtt  = r_result.smoothed_rtt;
    assign o_rtt_deviation = r_result.rtt_deviation;

    `RTTE_ASSERT_NEXT(a_timeout_arms_backoff, i_clk, i_rst_n, w_adv && (r_in_req == rtte_pkg::REQ_TIMEOUT), r_state.active)
    `RTTE_ASSERT_NEXT(a_sample_clears_backoff, i_clk, i_rst_n, w_adv && (r_in_req == rtte_pkg::REQ_SAMPLE), !r_state.active && (r_state.backoff == '0))
    `RTTE_ASSERT_IMP(a_state_in_range, i_clk, i_rst_n, 1'b1, (r_state.est != 16'hFFFF) && (r_state.dev != 16'hFFFF))

endmodule

`default_nettype wire
